/* rtl/core/btndb_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the button debounce / auto-repeat block.
// Used by btndb_cfg, btndb_qual and button_debounce_autorepeat. No dependencies.
package btndb_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgW-1:0] DebounceReset       = 16'd50;
    localparam logic [CfgW-1:0] HoldDelayReset      = 16'd500;
    localparam logic [CfgW-1:0] RepeatIntervalReset = 16'd250;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_HOLD     = 2'd1,
        CFG_REPEAT   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CfgW-1:0] debounce_len;
        logic [CfgW-1:0] hold_len;
        logic [CfgW-1:0] repeat_len;
    } t_cfg;

    // debounced status as seen after the last qualified sample
    typedef struct packed {
        logic pressed;
        logic prev_level;
    } t_qual_stat;

endpackage

/* rtl/core/btndb_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file: debounce, hold delay and repeat interval.
// Depends on btndb_pkg.
module btndb_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [btndb_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [btndb_pkg::CfgW-1:0]     i_cfg_data,
    output btndb_pkg::t_cfg                o_cfg
);

    btndb_pkg::t_cfg r_cfg;
    btndb_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (btndb_pkg::t_cfg_idx'(i_cfg_idx))
                btndb_pkg::CFG_DEBOUNCE: n_cfg.debounce_len = i_cfg_data;
                btndb_pkg::CFG_HOLD:     n_cfg.hold_len     = i_cfg_data;
                btndb_pkg::CFG_REPEAT:   n_cfg.repeat_len   = i_cfg_data;
                default:                 n_cfg = r_cfg; // unused index: ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_len <= btndb_pkg::DebounceReset;
            r_cfg.hold_len     <= btndb_pkg::HoldDelayReset;
            r_cfg.repeat_len   <= btndb_pkg::RepeatIntervalReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/btndb_qual.sv */
`timescale 1ns / 1ps
// Debounce and auto-repeat qualifier: button state and the per-sample decision.
// Depends on btndb_pkg.
module btndb_qual (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_level,
    input  logic [btndb_pkg::TimeW-1:0]   i_now,
    input  btndb_pkg::t_cfg               i_cfg,
    output logic                          o_fire,
    output btndb_pkg::t_qual_stat         o_stat
);

    logic                        r_prev_level;
    logic                        r_pressed;
    logic [btndb_pkg::TimeW-1:0] r_change_stamp;
    logic [btndb_pkg::TimeW-1:0] r_press_stamp;
    logic [btndb_pkg::TimeW-1:0] r_repeat_stamp;

    logic                        n_pressed;
    logic [btndb_pkg::TimeW-1:0] n_change_stamp;
    logic [btndb_pkg::TimeW-1:0] n_press_stamp;
    logic [btndb_pkg::TimeW-1:0] n_repeat_stamp;

    logic [btndb_pkg::TimeW-1:0] w_stable_t;
    logic [btndb_pkg::TimeW-1:0] w_held_t;
    logic [btndb_pkg::TimeW-1:0] w_since_rep_t;
    logic                        w_stable;
    logic                        w_held;
    logic                        w_rep_due;
    logic                        w_down;

    // differences wrap mod 2^32
    assign n_change_stamp = (i_level != r_prev_level) ? i_now : r_change_stamp;
    assign w_stable_t     = i_now - n_change_stamp;
    assign w_held_t       = i_now - r_press_stamp;
    assign w_since_rep_t  = i_now - r_repeat_stamp;
    assign w_stable  = w_stable_t    > {16'd0, i_cfg.debounce_len};
    assign w_held    = w_held_t      > {16'd0, i_cfg.hold_len};
    assign w_rep_due = w_since_rep_t > {16'd0, i_cfg.repeat_len};
    assign w_down    = !i_level;

    always_comb begin
        o_fire         = 1'b0;
        n_pressed      = r_pressed;
        n_press_stamp  = r_press_stamp;
        n_repeat_stamp = r_repeat_stamp;
        if (w_stable) begin
            priority if (w_down && !r_pressed) begin
                o_fire         = 1'b1;
                n_pressed      = 1'b1;
                n_press_stamp  = i_now;
                n_repeat_stamp = i_now;
            end else if (w_down) begin
                if (w_held && w_rep_due) begin
                    o_fire         = 1'b1;
                    n_repeat_stamp = i_now;
                end
            end else begin
                n_pressed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level   <= 1'b1;
            r_pressed      <= 1'b0;
            r_change_stamp <= '0;
            r_press_stamp  <= '0;
            r_repeat_stamp <= '0;
        end else if (i_en) begin
            r_prev_level   <= i_level;
            r_pressed      <= n_pressed;
            r_change_stamp <= n_change_stamp;
            r_press_stamp  <= n_press_stamp;
            r_repeat_stamp <= n_repeat_stamp;
        end
    end

    assign o_stat.pressed    = r_pressed;
    assign o_stat.prev_level = r_prev_level;

endmodule

/* rtl/core/button_debounce_autorepeat.sv */
`timescale 1ns / 1ps
// Top level: input register, qualifier stage, output register, config port.
// Depends on btndb_pkg, btndb_cfg, btndb_qual.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------
//  sample   | i_in_valid / o_in_ready    | i_pin_level, i_now_ms[31:0]
//  result   | o_out_valid / i_out_ready  | o_trigger
//  config   | i_cfg_we (no wait)         | i_cfg_idx[1:0], i_cfg_data[15:0]
//
// One sample per cycle sustained while results are taken. Path: input register,
// then the qualifier writes state and the output register in the same edge.
// Reset is synchronous; it clears both stage valids, the button state and the
// config registers to 50 / 500 / 250 ms.
// A stalled output holds the pipeline; o_in_ready falls only when both stages
// are full and the result is not taken.
module button_debounce_autorepeat (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_pin_level,
    input  logic [btndb_pkg::TimeW-1:0]   i_now_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_trigger,
    input  logic                          i_cfg_we,
    input  logic [btndb_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [btndb_pkg::CfgW-1:0]    i_cfg_data
);

    btndb_pkg::t_cfg       w_cfg;
    btndb_pkg::t_qual_stat w_stat;

    logic                        r_in_valid;
    logic                        r_level;
    logic [btndb_pkg::TimeW-1:0] r_now;
    logic                        r_out_valid;
    logic                        r_trigger;

    logic w_out_free;
    logic w_adv;
    logic w_take;
    logic w_fire;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign w_take     = i_in_valid && o_in_ready;

    btndb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    btndb_qual u_qual (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_level (r_level),
        .i_now   (r_now),
        .i_cfg   (w_cfg),
        .o_fire  (w_fire),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_level <= i_pin_level;
            r_now   <= i_now_ms;
        end
        if (w_adv) begin
            r_trigger <= w_fire;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_trigger   = r_trigger;

    // first cycle out of reset shows no result
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // a new result only appears behind a filled input stage
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result valid without a sample in the input stage");

    // every trigger leaves the button in the pressed state
    a_fire_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_fire) |=> w_stat.pressed)
        else $error("trigger issued but pressed state not set");

endmodule
